>>> design/aht_pkg.sv
// ----------------------------------------------------------------------------
// aht_pkg
// shared types and constants of the access hotspot table
// ----------------------------------------------------------------------------
package aht_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int HASH_SHIFT_HI   = 12;
    localparam int HASH_SHIFT_LO   = 6;
    localparam int SLOT_W          = 6;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OUT_HIT    = 2'd0,
        OUT_INSERT = 2'd1,
        OUT_EVICT  = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] pc;
        logic        write_op;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_outcome          outcome;
        logic [31:0]       evicted_addr;
        logic [31:0]       total_count;
        logic [31:0]       read_count;
        logic [31:0]       write_count;
    } t_result;

endpackage

>>> design/aht_fifo.sv
// ----------------------------------------------------------------------------
// aht_fifo
// short register queue, power-of-two depth
// ----------------------------------------------------------------------------
module aht_fifo import aht_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [AW:0]      r_count, n_count;
    logic             s_do_push;
    logic             s_do_pop;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rptr];
    assign s_do_push = i_push && !o_full;
    assign s_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = s_do_push ? r_wptr + AW'(1) : r_wptr;
        n_rptr  = s_do_pop  ? r_rptr + AW'(1) : r_rptr;
        n_count = r_count;
        if (s_do_push && !s_do_pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (s_do_pop && !s_do_push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_do_push && !s_do_pop) |=> r_count == $past(r_count) + (AW+1)'(1))
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_do_pop && !s_do_push) |=> r_count == $past(r_count) - (AW+1)'(1))
        else $error("queue count missed a pop");
`endif

endmodule

>>> design/aht_front.sv
// ----------------------------------------------------------------------------
// aht_front
// input stage: takes accesses and computes the home slot
// ----------------------------------------------------------------------------
module aht_front import aht_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  t_item                          i_item,
    output logic                           o_full,
    input  logic                           i_hold,
    output logic                           o_valid,
    output t_item                          o_item,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_home,
    input  logic                           i_q_full
);

    localparam int IDXW = $clog2(TABLE_SLOTS);

    logic            r_vld, n_vld;
    t_item           r_item;
    logic [IDXW-1:0] r_home;
    logic [31:0]     s_h1;
    logic [31:0]     s_h2;
    logic [31:0]     s_hm;
    logic            s_accept;

    assign s_h1     = i_item.addr ^ (i_item.addr >> HASH_SHIFT_HI);
    assign s_h2     = s_h1 ^ (s_h1 >> HASH_SHIFT_LO);
    assign s_hm     = s_h2 & 32'(TABLE_SLOTS - 1);
    assign o_full   = i_hold || (r_vld && i_q_full);
    assign s_accept = i_push && !o_full;
    assign o_valid  = r_vld;
    assign o_item   = r_item;
    assign o_home   = r_home;

    always_comb begin
        n_vld = r_vld;
        if (s_accept) begin
            n_vld = 1'b1;
        end else if (r_vld && !i_q_full) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item <= i_item;
            r_home <= s_hm[IDXW-1:0];
        end
    end

endmodule

>>> design/aht_back.sv
// ----------------------------------------------------------------------------
// aht_back
// probe and update engine: linear probing, least-count eviction scan
// ----------------------------------------------------------------------------
module aht_back import aht_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_mid_empty,
    input  t_item                          i_mid_item,
    input  logic [$clog2(TABLE_SLOTS)-1:0] i_mid_home,
    output logic                           o_mid_pop,
    output logic                           o_hold,
    output logic                           o_res_push,
    output t_result                        o_result,
    input  logic                           i_res_full
);

    localparam int IDXW = $clog2(TABLE_SLOTS);
    localparam logic [IDXW-1:0] LAST = IDXW'(TABLE_SLOTS - 1);

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] pc;
        logic [31:0] total;
        logic [31:0] reads;
        logic [31:0] writes;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLR   = 5'b00001,
        S_IDLE  = 5'b00010,
        S_CHK   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EVICT = 5'b10000
    } t_state;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    t_entry          r_mem [TABLE_SLOTS];
    t_entry          r_rdata;
    t_state          r_state, n_state;
    t_item           r_item, n_item;
    logic [IDXW-1:0] r_idx, n_idx;
    logic [IDXW-1:0] r_probe, n_probe;
    logic [IDXW-1:0] r_clr, n_clr;
    logic [IDXW-1:0] r_scan, n_scan;
    logic [IDXW-1:0] r_cmp, n_cmp;
    logic            r_sv, n_sv;
    logic            r_sdone, n_sdone;
    logic [IDXW-1:0] r_best_idx, n_best_idx;
    logic [31:0]     r_best_tot, n_best_tot;
    logic [31:0]     r_best_key, n_best_key;
    logic [IDXW-1:0] s_rd_addr;
    logic            s_we;
    logic [IDXW-1:0] s_wa;
    t_entry          s_wd;
    logic            s_match;
    logic [IDXW-1:0] s_idx_inc;
    logic [31:0]     s_tot_base;
    logic [31:0]     s_rd_base;
    logic [31:0]     s_wr_base;

    assign s_match   = r_rdata.valid && (r_rdata.key == r_item.addr);
    assign s_idx_inc = (r_idx == LAST) ? '0 : r_idx + IDXW'(1);
    assign s_tot_base = r_rdata.valid ? r_rdata.total  : 32'd0;
    assign s_rd_base  = r_rdata.valid ? r_rdata.reads  : 32'd0;
    assign s_wr_base  = r_rdata.valid ? r_rdata.writes : 32'd0;
    assign o_hold    = (r_state == S_CLR);

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_idx      = r_idx;
        n_probe    = r_probe;
        n_clr      = r_clr;
        n_scan     = r_scan;
        n_cmp      = r_cmp;
        n_sv       = 1'b0;
        n_sdone    = r_sdone;
        n_best_idx = r_best_idx;
        n_best_tot = r_best_tot;
        n_best_key = r_best_key;
        s_rd_addr  = r_idx;
        s_we       = 1'b0;
        s_wa       = r_idx;
        s_wd       = '0;
        o_mid_pop  = 1'b0;
        o_res_push = 1'b0;
        o_result   = '0;
        unique case (r_state)
            S_CLR: begin
                s_we = 1'b1;
                s_wa = r_clr;
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + IDXW'(1);
                end
            end
            S_IDLE: begin
                s_rd_addr = i_mid_home;
                if (!i_mid_empty && !i_res_full) begin
                    o_mid_pop = 1'b1;
                    n_item    = i_mid_item;
                    n_idx     = i_mid_home;
                    n_probe   = '0;
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                if (!r_rdata.valid || s_match) begin
                    s_we         = 1'b1;
                    s_wa         = r_idx;
                    s_wd.valid   = 1'b1;
                    s_wd.key     = r_item.addr;
                    s_wd.pc      = r_item.pc;
                    s_wd.total   = sat_inc(s_tot_base);
                    s_wd.reads   = r_item.write_op ? s_rd_base : sat_inc(s_rd_base);
                    s_wd.writes  = r_item.write_op ? sat_inc(s_wr_base) : s_wr_base;
                    o_res_push   = 1'b1;
                    o_result.slot         = SLOT_W'(r_idx);
                    o_result.outcome      = s_match ? OUT_HIT : OUT_INSERT;
                    o_result.evicted_addr = 32'd0;
                    o_result.total_count  = s_wd.total;
                    o_result.read_count   = s_wd.reads;
                    o_result.write_count  = s_wd.writes;
                    n_state = S_IDLE;
                end else if (r_probe == LAST) begin
                    n_scan  = '0;
                    n_sdone = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    s_rd_addr = s_idx_inc;
                    n_idx     = s_idx_inc;
                    n_probe   = r_probe + IDXW'(1);
                end
            end
            S_SCAN: begin
                s_rd_addr = r_scan;
                n_sv      = !r_sdone;
                n_cmp     = r_scan;
                if (r_scan == LAST) begin
                    n_sdone = 1'b1;
                end else begin
                    n_scan = r_scan + IDXW'(1);
                end
                if (r_sv) begin
                    if (r_cmp == '0 || r_rdata.total < r_best_tot) begin
                        n_best_idx = r_cmp;
                        n_best_tot = r_rdata.total;
                        n_best_key = r_rdata.key;
                    end
                    if (r_cmp == LAST) begin
                        n_sv    = 1'b0;
                        n_state = S_EVICT;
                    end
                end
            end
            S_EVICT: begin
                s_we        = 1'b1;
                s_wa        = r_best_idx;
                s_wd.valid  = 1'b1;
                s_wd.key    = r_item.addr;
                s_wd.pc     = r_item.pc;
                s_wd.total  = 32'd1;
                s_wd.reads  = r_item.write_op ? 32'd0 : 32'd1;
                s_wd.writes = r_item.write_op ? 32'd1 : 32'd0;
                o_res_push  = 1'b1;
                o_result.slot         = SLOT_W'(r_best_idx);
                o_result.outcome      = OUT_EVICT;
                o_result.evicted_addr = r_best_key;
                o_result.total_count  = s_wd.total;
                o_result.read_count   = s_wd.reads;
                o_result.write_count  = s_wd.writes;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_sv    <= 1'b0;
            r_sdone <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_sv    <= n_sv;
            r_sdone <= n_sdone;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_probe    <= n_probe;
        r_scan     <= n_scan;
        r_cmp      <= n_cmp;
        r_best_idx <= n_best_idx;
        r_best_tot <= n_best_tot;
        r_best_key <= n_best_key;
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_wa] <= s_wd;
        end
        r_rdata <= r_mem[s_rd_addr];
    end

`ifndef NO_ASSERTIONS
    a_push_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (r_state == S_CHK || r_state == S_EVICT))
        else $error("result beat outside check or evict");

    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mid_pop |-> (!i_res_full && r_state == S_IDLE))
        else $error("item taken without result room");

    a_evict_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVICT |=> r_state == S_IDLE)
        else $error("evict did not return to idle");

    a_clear_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> (!o_mid_pop && !o_res_push))
        else $error("activity during clearing pass");
`endif

endmodule

>>> design/access_hotspot_table_core.sv
// ----------------------------------------------------------------------------
// access_hotspot_table_core
// per-address access counter table with linear probing and least-count
// eviction
//
//   channel   dir   handshake              payload
//   access    in    i_push / o_full        i_item   (t_item)
//   result    out   o_empty / i_pop        o_result (t_result)
//
// after reset a clearing pass over all TABLE_SLOTS slots runs with o_full high
// a hit or insert stops the probe at the first free or matching slot
// an eviction probes all TABLE_SLOTS slots, then scans them for the least count
// two-entry queues before and after the engine absorb stalls on either side
// ----------------------------------------------------------------------------
module access_hotspot_table_core import aht_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    output logic    o_full,
    input  logic    i_pop,
    output t_result o_result,
    output logic    o_empty
);

    localparam int IDXW  = $clog2(TABLE_SLOTS);
    localparam int MID_W = $bits(t_item) + IDXW;
    localparam int RES_W = $bits(t_result);

    logic             s_hold;
    logic             s_f_valid;
    t_item            s_f_item;
    logic [IDXW-1:0]  s_f_home;
    logic             s_mid_full;
    logic             s_mid_empty;
    logic             s_mid_pop;
    logic [MID_W-1:0] s_mid_rdata;
    t_item            s_mid_item;
    logic [IDXW-1:0]  s_mid_home;
    logic             s_res_push;
    t_result          s_res;
    logic             s_res_full;
    logic [RES_W-1:0] s_res_rdata;

    assign s_mid_item = t_item'(s_mid_rdata[MID_W-1:IDXW]);
    assign s_mid_home = s_mid_rdata[IDXW-1:0];
    assign o_result   = t_result'(s_res_rdata);

    aht_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .o_full   (o_full),
        .i_hold   (s_hold),
        .o_valid  (s_f_valid),
        .o_item   (s_f_item),
        .o_home   (s_f_home),
        .i_q_full (s_mid_full)
    );

    aht_fifo #(
        .WIDTH (MID_W),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_f_valid),
        .i_data  ({s_f_item, s_f_home}),
        .o_full  (s_mid_full),
        .i_pop   (s_mid_pop),
        .o_data  (s_mid_rdata),
        .o_empty (s_mid_empty)
    );

    aht_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (s_mid_empty),
        .i_mid_item  (s_mid_item),
        .i_mid_home  (s_mid_home),
        .o_mid_pop   (s_mid_pop),
        .o_hold      (s_hold),
        .o_res_push  (s_res_push),
        .o_result    (s_res),
        .i_res_full  (s_res_full)
    );

    aht_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_res_push),
        .i_data  (s_res),
        .o_full  (s_res_full),
        .i_pop   (i_pop),
        .o_data  (s_res_rdata),
        .o_empty (o_empty)
    );

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for access_hotspot_table_core
//
// a queue of access beats feeds a clocked driver; every accepted beat runs
// through a local copy of the hash table (probing, insert, least-count
// eviction) and the predicted slot update is queued; a clocked monitor pops
// result beats under random back-pressure and compares every field
// a short directed part covers address and pc extremes, shared home slots,
// probing that wraps past the last slot and hits after long probes; the
// random part mixes a hot working set with fresh addresses so that the
// table fills and then runs in eviction for most of the test
// ----------------------------------------------------------------------------
module tb;
    import aht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = TABLE_SLOTS_DEF;
    localparam int RANDOM_ITEMS   = 1830;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int PRINT_LIMIT    = 40;

    typedef struct {
        t_item item;
        int    gap;
        bit    drain;
    } t_access_req;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_push  = 1'b0;
    t_item   i_item  = '0;
    logic    o_full;
    logic    i_pop   = 1'b0;
    t_result o_result;
    logic    o_empty;

    t_access_req access_q[$];
    t_result     slot_update_q[$];

    // local copy of the table
    bit          tbl_valid  [SLOTS];
    logic [31:0] tbl_key    [SLOTS];
    logic [31:0] tbl_pc     [SLOTS];
    logic [31:0] tbl_total  [SLOTS];
    logic [31:0] tbl_reads  [SLOTS];
    logic [31:0] tbl_writes [SLOTS];

    int mismatches    = 0;
    int beats_in      = 0;
    int beats_out     = 0;
    int n_hit         = 0;
    int n_insert      = 0;
    int n_evict       = 0;
    int longest_probe = 0;
    int wrapped_runs  = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    bit gap_loaded    = 1'b0;
    int pop_wait      = 0;
    int pop_steady    = 0;
    int pop_pick;
    int stall_cycles  = 0;

    access_hotspot_table_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .o_full   (o_full),
        .i_pop    (i_pop),
        .o_result (o_result),
        .o_empty  (o_empty)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [SLOT_W-1:0] home_slot(logic [31:0] a);
        logic [31:0] h;
        h = a ^ (a >> HASH_SHIFT_HI);
        h = h ^ (h >> HASH_SHIFT_LO);
        return h[SLOT_W-1:0];
    endfunction

    function automatic logic [31:0] sat_bump(logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] addr_for_slot(int target);
        logic [31:0] a;
        do begin
            a = $urandom;
        end while (home_slot(a) != target[SLOT_W-1:0]);
        return a;
    endfunction

    function automatic t_result account_access(t_item acc);
        t_result           r;
        logic [SLOT_W-1:0] home;
        logic [SLOT_W-1:0] idx;
        int                probe_len;
        int                best;
        bit                placed;
        r         = '0;
        home      = home_slot(acc.addr);
        idx       = home;
        probe_len = 0;
        placed    = 1'b0;
        while (!placed && probe_len < SLOTS) begin
            if (!tbl_valid[idx]) begin
                tbl_valid[idx]  = 1'b1;
                tbl_key[idx]    = acc.addr;
                tbl_total[idx]  = '0;
                tbl_reads[idx]  = '0;
                tbl_writes[idx] = '0;
                r.outcome       = OUT_INSERT;
                placed          = 1'b1;
            end else if (tbl_key[idx] == acc.addr) begin
                r.outcome = OUT_HIT;
                placed    = 1'b1;
            end else begin
                idx       = idx + SLOT_W'(1);
                probe_len = probe_len + 1;
            end
        end
        if (placed) begin
            tbl_total[idx] = sat_bump(tbl_total[idx]);
            tbl_pc[idx]    = acc.pc;
            if (acc.write_op) begin
                tbl_writes[idx] = sat_bump(tbl_writes[idx]);
            end else begin
                tbl_reads[idx] = sat_bump(tbl_reads[idx]);
            end
            if (probe_len > longest_probe) longest_probe = probe_len;
            if (idx < home) wrapped_runs++;
            if (r.outcome == OUT_HIT) n_hit++;
            else n_insert++;
        end else begin
            best = 0;
            for (int i = 1; i < SLOTS; i++) begin
                if (tbl_total[i] < tbl_total[best]) best = i;
            end
            idx             = best[SLOT_W-1:0];
            r.outcome       = OUT_EVICT;
            r.evicted_addr  = tbl_key[idx];
            tbl_key[idx]    = acc.addr;
            tbl_pc[idx]     = acc.pc;
            tbl_total[idx]  = 32'd1;
            tbl_reads[idx]  = acc.write_op ? 32'd0 : 32'd1;
            tbl_writes[idx] = acc.write_op ? 32'd1 : 32'd0;
            n_evict++;
        end
        r.slot        = idx;
        r.total_count = tbl_total[idx];
        r.read_count  = tbl_reads[idx];
        r.write_count = tbl_writes[idx];
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatches < PRINT_LIMIT) $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("beat %0d %s got %h want %h", beats_out, name, got, want));
        end
    endtask

    task automatic queue_access(logic [31:0] addr, logic [31:0] pc, logic wr, bit drain);
        t_access_req req;
        int          pick;
        req.item.addr     = addr;
        req.item.pc       = pc;
        req.item.write_op = wr;
        req.drain         = drain;
        if (burst_left > 0) begin
            burst_left--;
            req.gap = 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                burst_left = $urandom_range(20, 80);
                req.gap    = 0;
            end else if (pick < 55) begin
                req.gap = 0;
            end else if (pick < 88) begin
                req.gap = $urandom_range(1, 3);
            end else if (pick < 97) begin
                req.gap = $urandom_range(4, 12);
            end else begin
                req.gap = $urandom_range(30, 90);
            end
        end
        access_q.push_back(req);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push     <= 1'b0;
            gap_loaded = 1'b0;
        end else begin
            if (i_push && !o_full) begin
                slot_update_q.push_back(account_access(i_item));
                void'(access_q.pop_front());
                beats_in++;
                gap_loaded = 1'b0;
            end
            if (i_push && o_full) begin
                // hold the beat until taken
            end else if (access_q.size() == 0) begin
                i_push <= 1'b0;
            end else begin
                if (!gap_loaded) begin
                    gap_left   = access_q[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_push <= 1'b0;
                end else if (access_q[0].drain && slot_update_q.size() != 0) begin
                    i_push <= 1'b0;
                end else begin
                    i_push <= 1'b1;
                    i_item <= access_q[0].item;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (slot_update_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat %0d on slot %0d",
                                            beats_out, o_result.slot));
                end else begin
                    t_result want;
                    want = slot_update_q.pop_front();
                    check_field("slot", 32'(o_result.slot), 32'(want.slot));
                    check_field("outcome", 32'(o_result.outcome), 32'(want.outcome));
                    check_field("evicted_addr", o_result.evicted_addr, want.evicted_addr);
                    check_field("total_count", o_result.total_count, want.total_count);
                    check_field("read_count", o_result.read_count, want.read_count);
                    check_field("write_count", o_result.write_count, want.write_count);
                end
                beats_out++;
            end
            if (pop_steady > 0) begin
                pop_steady--;
                i_pop <= 1'b1;
            end else if (pop_wait > 0) begin
                pop_wait--;
                i_pop <= 1'b0;
            end else begin
                pop_pick = $urandom_range(0, 99);
                if (pop_pick < 2) begin
                    pop_steady = $urandom_range(50, 300);
                    i_pop <= 1'b1;
                end else if (pop_pick < 5) begin
                    pop_wait = $urandom_range(20, 80);
                    i_pop <= 1'b0;
                end else if (pop_pick < 30) begin
                    pop_wait = $urandom_range(0, 3);
                    i_pop <= 1'b0;
                end else begin
                    i_pop <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [31:0] a;
        logic [31:0] wrap_addr [5];
        logic [31:0] mid_addr  [3];
        logic [31:0] hot_q[$];
        logic [31:0] recent_q[$];
        int          pick;

        // address 0 and all-ones share home slot 0
        queue_access(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        queue_access(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_access(32'hFFFF_FFFF, 32'h5555_5555, 1'b1, 1'b0);
        queue_access(32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, 1'b0);
        // home on the last slot, probing wraps to the bottom
        for (int n = 0; n < 5; n++) begin
            wrap_addr[n] = addr_for_slot(SLOTS - 1);
            queue_access(wrap_addr[n], $urandom, n[0], 1'b0);
            hot_q.push_back(wrap_addr[n]);
        end
        queue_access(wrap_addr[4], 32'h0000_0000, 1'b1, 1'b0);
        queue_access(wrap_addr[4], 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_access(wrap_addr[0], $urandom, 1'b1, 1'b0);
        for (int n = 0; n < 3; n++) begin
            mid_addr[n] = addr_for_slot(SLOTS / 3);
            queue_access(mid_addr[n], $urandom, 1'b0, 1'b0);
            hot_q.push_back(mid_addr[n]);
        end
        queue_access(mid_addr[2], $urandom, 1'b1, 1'b0);
        queue_access(32'h0000_0000, $urandom, 1'b0, 1'b0);
        hot_q.push_back(32'h0000_0000);
        hot_q.push_back(32'hFFFF_FFFF);
        recent_q.push_back(32'hFFFF_FFFF);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                if ($urandom_range(0, 4) == 0) a = addr_for_slot($urandom_range(SLOTS - 8, SLOTS - 1));
                else a = $urandom;
                recent_q.push_back(a);
                if (recent_q.size() > 6) void'(recent_q.pop_front());
                if (hot_q.size() < 40) hot_q.push_back(a);
                else if ($urandom_range(0, 7) == 0) hot_q[$urandom_range(0, 39)] = a;
            end else if (pick < 34) begin
                a = recent_q[$urandom_range(0, recent_q.size() - 1)];
            end else begin
                a = hot_q[$urandom_range(0, hot_q.size() - 1)];
            end
            queue_access(a, $urandom, 1'($urandom_range(0, 1)),
                         (n == 0) || (n == RANDOM_ITEMS / 2));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (access_q.size() != 0 || slot_update_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d accesses: %0d hits, %0d inserts, %0d evictions",
                 beats_in, n_hit, n_insert, n_evict);
        $display("longest probe %0d slots, %0d probe runs wrapped past the last slot",
                 longest_probe, wrapped_runs);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/aht_pkg.sv
design/aht_fifo.sv
design/aht_front.sv
design/aht_back.sv
design/access_hotspot_table_core.sv
bench/tb.sv
